// ===== rtl/fbm_pkg.sv =====
// fbm_pkg: shared widths, reset values, register codes and stage word types
// for the flow balance monitor; no dependencies
`default_nettype none

package fbm_pkg;

    // samples per block, a power of two so the average is a shift
    localparam int AVG_LOG2    = 4;
    localparam int AVG_SAMPLES = 1 << AVG_LOG2;
    localparam int SAMPLE_BITS = 10;

    localparam int CNT_W  = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
    localparam int SUM_W  = SAMPLE_BITS + AVG_LOG2;
    localparam int WIN_W  = 32;
    localparam int TIME_W = 32;
    localparam int WMS_W  = 16;
    localparam int ZERO_W = 10;
    localparam int GAIN_W = 16;
    localparam int ICPT_W = 16;
    localparam int FLOW_W = 20;

    // flow scaling widths
    localparam int ZN_W       = ZERO_W + AVG_LOG2;
    localparam int DIFF_W     = ((SUM_W > ZN_W) ? SUM_W : ZN_W) + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W;
    localparam int FRAC_SHIFT = 8 + AVG_LOG2;
    localparam int QUOT_W     = PROD_W - FRAC_SHIFT;
    localparam int ADD_W      = ((QUOT_W > ICPT_W) ? QUOT_W : ICPT_W) + 1;

    // balance check widths: feed sum and products by 19, 20, 21
    localparam int FEED_W = WIN_W + 1;
    localparam int CHK_W  = FEED_W + 5;
    localparam int BAL_LO  = 19;
    localparam int BAL_REF = 20;
    localparam int BAL_HI  = 21;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WMS_W-1:0]  WINDOW_MS_RST = 16'd3000;
    localparam logic [ZERO_W-1:0] ZERO_RST      = 10'd68;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd17367;
    localparam logic [ICPT_W-1:0] ICPT_RST      = 16'd691;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_MS  = 2'd0,
        REG_ZERO_COUNT = 2'd1,
        REG_GAIN       = 2'd2,
        REG_INTERCEPT  = 2'd3
    } cfg_reg_t;

    // completed block sums with the timestamp of the closing word
    typedef struct packed {
        logic [SUM_W-1:0]  oxygen;
        logic [SUM_W-1:0]  air;
        logic [SUM_W-1:0]  patient;
        logic [TIME_W-1:0] now_ms;
    } blk_t;

    // scaled products and status after the window update
    typedef struct packed {
        logic signed [PROD_W-1:0] oxygen;
        logic signed [PROD_W-1:0] air;
        logic signed [PROD_W-1:0] patient;
        logic                     balance_error;
        logic                     window_checked;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/fbm_accum.sv =====
// fbm_accum: block accumulator, sums AVG_SAMPLES words per channel and
// registers the finished block; depends on fbm_pkg
`default_nettype none

module fbm_accum import fbm_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_oxygen_sample,
    input  wire logic [SAMPLE_BITS-1:0] s_air_sample,
    input  wire logic [SAMPLE_BITS-1:0] s_patient_sample,
    input  wire logic [TIME_W-1:0]      s_now_ms,
    output logic                        blk_valid,
    input  wire logic                   blk_ready,
    output blk_t                        blk_data
);

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] ox_sum_reg, air_sum_reg, pt_sum_reg;
    logic [SUM_W-1:0] ox_sum_next, air_sum_next, pt_sum_next;
    logic             blk_valid_reg;
    blk_t             blk_reg;
    logic             last_word;
    logic             accept;

    assign last_word = (count_reg == CNT_W'(AVG_SAMPLES - 1));
    // only the closing word of a block needs room in the stage register
    assign s_ready   = !last_word || !blk_valid_reg || blk_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        ox_sum_next  = ox_sum_reg  + SUM_W'(s_oxygen_sample);
        air_sum_next = air_sum_reg + SUM_W'(s_air_sample);
        pt_sum_next  = pt_sum_reg  + SUM_W'(s_patient_sample);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ox_sum_reg    <= '0;
            air_sum_reg   <= '0;
            pt_sum_reg    <= '0;
            blk_valid_reg <= 1'b0;
        end else begin
            if (accept && last_word) begin
                blk_valid_reg <= 1'b1;
            end else if (blk_ready) begin
                blk_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (last_word) begin
                    count_reg     <= '0;
                    ox_sum_reg    <= '0;
                    air_sum_reg   <= '0;
                    pt_sum_reg    <= '0;
                end else begin
                    count_reg   <= count_reg + CNT_W'(1);
                    ox_sum_reg  <= ox_sum_next;
                    air_sum_reg <= air_sum_next;
                    pt_sum_reg  <= pt_sum_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last_word) begin
            blk_reg.oxygen  <= ox_sum_next;
            blk_reg.air     <= air_sum_next;
            blk_reg.patient <= pt_sum_next;
            blk_reg.now_ms  <= s_now_ms;
        end
    end

    assign blk_valid = blk_valid_reg;
    assign blk_data  = blk_reg;

endmodule

`default_nettype wire

// ===== rtl/fbm_update.sv =====
// fbm_update: saturating window sums, timed balance check and the offset
// times gain products for one block; depends on fbm_pkg
`default_nettype none

module fbm_update import fbm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [WMS_W-1:0]  window_ms,
    input  wire logic [ZERO_W-1:0] zero_count,
    input  wire logic [GAIN_W-1:0] gain_q16,
    input  wire logic              blk_valid,
    output logic                   blk_ready,
    input  wire blk_t              blk_data,
    output logic                   upd_valid,
    input  wire logic              upd_ready,
    output upd_t                   upd_data
);

    logic [WIN_W-1:0]  ox_win_reg, air_win_reg, pt_win_reg;
    logic [WIN_W-1:0]  ox_win_sat, air_win_sat, pt_win_sat;
    logic [TIME_W-1:0] last_check_reg;
    logic              error_reg;
    logic              error_next;
    logic              do_check;
    logic [TIME_W-1:0] elapsed;
    logic [FEED_W-1:0] feed;
    logic [CHK_W-1:0]  pt20, feed19, feed21;
    logic              upd_valid_reg;
    upd_t              upd_reg;
    upd_t              upd_next;
    logic              load;

    logic signed [DIFF_W-1:0] zero_n;
    logic signed [DIFF_W-1:0] ox_diff, air_diff, pt_diff;
    logic signed [PROD_W-1:0] gain_s;

    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] w,
                                                 input logic [SUM_W-1:0] s);
        logic [WIN_W:0] t;
        t = {1'b0, w} + (WIN_W + 1)'(s);
        return t[WIN_W] ? '1 : t[WIN_W-1:0];
    endfunction

    assign blk_ready = !upd_valid_reg || upd_ready;
    assign load      = blk_valid && blk_ready;

    always_comb begin
        ox_win_sat  = sat_add(ox_win_reg,  blk_data.oxygen);
        air_win_sat = sat_add(air_win_reg, blk_data.air);
        pt_win_sat  = sat_add(pt_win_reg,  blk_data.patient);

        elapsed  = blk_data.now_ms - last_check_reg;
        do_check = (elapsed >= TIME_W'(window_ms));

        // exact check on raw sums: 19*feed <= 20*patient <= 21*feed
        feed   = FEED_W'(ox_win_sat) + FEED_W'(air_win_sat);
        pt20   = CHK_W'(pt_win_sat) * CHK_W'(BAL_REF);
        feed19 = CHK_W'(feed) * CHK_W'(BAL_LO);
        feed21 = CHK_W'(feed) * CHK_W'(BAL_HI);
        error_next = do_check ? ((pt20 < feed19) || (pt20 > feed21)) : error_reg;

        zero_n   = DIFF_W'({zero_count, {AVG_LOG2{1'b0}}});
        ox_diff  = $signed(DIFF_W'(blk_data.oxygen))  - zero_n;
        air_diff = $signed(DIFF_W'(blk_data.air))     - zero_n;
        pt_diff  = $signed(DIFF_W'(blk_data.patient)) - zero_n;
        gain_s   = $signed(PROD_W'(gain_q16));

        upd_next.oxygen         = PROD_W'(ox_diff)  * gain_s;
        upd_next.air            = PROD_W'(air_diff) * gain_s;
        upd_next.patient        = PROD_W'(pt_diff)  * gain_s;
        upd_next.balance_error  = error_next;
        upd_next.window_checked = do_check;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_win_reg     <= '0;
            air_win_reg    <= '0;
            pt_win_reg     <= '0;
            last_check_reg <= '0;
            error_reg      <= 1'b0;
            upd_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                upd_valid_reg <= 1'b1;
            end else if (upd_ready) begin
                upd_valid_reg <= 1'b0;
            end
            if (load) begin
                error_reg     <= error_next;
                if (do_check) begin
                    last_check_reg <= blk_data.now_ms;
                    ox_win_reg     <= '0;
                    air_win_reg    <= '0;
                    pt_win_reg     <= '0;
                end else begin
                    ox_win_reg  <= ox_win_sat;
                    air_win_reg <= air_win_sat;
                    pt_win_reg  <= pt_win_sat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            upd_reg <= upd_next;
        end
    end

    assign upd_valid = upd_valid_reg;
    assign upd_data  = upd_reg;

endmodule

`default_nettype wire

// ===== rtl/fbm_scale.sv =====
// fbm_scale: floor shift, intercept add and saturation into the result
// register; depends on fbm_pkg
`default_nettype none

module fbm_scale import fbm_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic signed [ICPT_W-1:0] intercept_q8,
    input  wire logic                     upd_valid,
    output logic                          upd_ready,
    input  wire upd_t                     upd_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [FLOW_W-1:0]      m_oxygen_flow,
    output logic signed [FLOW_W-1:0]      m_air_flow,
    output logic signed [FLOW_W-1:0]      m_patient_flow,
    output logic                          m_balance_error,
    output logic                          m_window_checked
);

    localparam logic signed [ADD_W-1:0] FLOW_HI = ADD_W'((1 << (FLOW_W - 1)) - 1);
    localparam logic signed [ADD_W-1:0] FLOW_LO = -ADD_W'(1 << (FLOW_W - 1));

    logic                     m_valid_reg;
    logic signed [FLOW_W-1:0] ox_flow_reg, air_flow_reg, pt_flow_reg;
    logic                     error_reg, checked_reg;
    logic signed [FLOW_W-1:0] ox_flow_next, air_flow_next, pt_flow_next;
    logic                     load;

    // arithmetic shift floors toward minus infinity
    function automatic logic signed [FLOW_W-1:0] to_flow(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [ICPT_W-1:0] icpt);
        logic signed [PROD_W-1:0] sh;
        logic signed [ADD_W-1:0]  q;
        sh = prod >>> FRAC_SHIFT;
        q  = ADD_W'($signed(sh[QUOT_W-1:0])) + ADD_W'(icpt);
        if (q > FLOW_HI) begin
            return FLOW_W'(FLOW_HI);
        end else if (q < FLOW_LO) begin
            return FLOW_W'(FLOW_LO);
        end
        return FLOW_W'(q);
    endfunction

    assign upd_ready = !m_valid_reg || m_ready;
    assign load      = upd_valid && upd_ready;

    always_comb begin
        ox_flow_next  = to_flow(upd_data.oxygen,  intercept_q8);
        air_flow_next = to_flow(upd_data.air,     intercept_q8);
        pt_flow_next  = to_flow(upd_data.patient, intercept_q8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ox_flow_reg  <= ox_flow_next;
            air_flow_reg <= air_flow_next;
            pt_flow_reg  <= pt_flow_next;
            error_reg    <= upd_data.balance_error;
            checked_reg  <= upd_data.window_checked;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_oxygen_flow    = ox_flow_reg;
    assign m_air_flow       = air_flow_reg;
    assign m_patient_flow   = pt_flow_reg;
    assign m_balance_error  = error_reg;
    assign m_window_checked = checked_reg;

endmodule

`default_nettype wire

// ===== rtl/flow_balance_monitor_unit.sv =====
// flow_balance_monitor_unit: top level with configuration registers and
// the accumulate, update and scale stages; depends on fbm_pkg and fbm_*
`default_nettype none

// Takes one word of three flow samples and a ms timestamp per clock and
// emits one result word for every AVG_SAMPLES (16) words taken: three
// averaged flows in signed Q8 and the balance status. The result leaves
// three register stages after the closing word of a block (accumulator,
// window update with the gain multipliers, output scaling), so the block
// sustains one input word per cycle; a stalled output only holds the input
// once the closing word of the next block finds every stage full. The
// balance check runs when (now_ms - last check) reaches window_ms; the
// check time starts at zero after reset. Write configuration only while
// no block is in flight.
module flow_balance_monitor_unit import fbm_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_oxygen_sample,
    input  wire logic [SAMPLE_BITS-1:0] s_air_sample,
    input  wire logic [SAMPLE_BITS-1:0] s_patient_sample,
    input  wire logic [TIME_W-1:0]      s_now_ms,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [FLOW_W-1:0]    m_oxygen_flow,
    output logic signed [FLOW_W-1:0]    m_air_flow,
    output logic signed [FLOW_W-1:0]    m_patient_flow,
    output logic                        m_balance_error,
    output logic                        m_window_checked
);

    logic [WMS_W-1:0]         window_ms_reg;
    logic [ZERO_W-1:0]        zero_count_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [ICPT_W-1:0] intercept_reg;

    logic blk_valid, blk_ready;
    blk_t blk_data;
    logic upd_valid, upd_ready;
    upd_t upd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ms_reg  <= WINDOW_MS_RST;
            zero_count_reg <= ZERO_RST;
            gain_reg       <= GAIN_RST;
            intercept_reg  <= ICPT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_MS:  window_ms_reg  <= cfg_wdata[WMS_W-1:0];
                REG_ZERO_COUNT: zero_count_reg <= cfg_wdata[ZERO_W-1:0];
                REG_GAIN:       gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_INTERCEPT:  intercept_reg  <= cfg_wdata[ICPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbm_accum u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_oxygen_sample  (s_oxygen_sample),
        .s_air_sample     (s_air_sample),
        .s_patient_sample (s_patient_sample),
        .s_now_ms         (s_now_ms),
        .blk_valid        (blk_valid),
        .blk_ready        (blk_ready),
        .blk_data         (blk_data)
    );

    fbm_update u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .window_ms  (window_ms_reg),
        .zero_count (zero_count_reg),
        .gain_q16   (gain_reg),
        .blk_valid  (blk_valid),
        .blk_ready  (blk_ready),
        .blk_data   (blk_data),
        .upd_valid  (upd_valid),
        .upd_ready  (upd_ready),
        .upd_data   (upd_data)
    );

    fbm_scale u_scale (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .intercept_q8     (intercept_reg),
        .upd_valid        (upd_valid),
        .upd_ready        (upd_ready),
        .upd_data         (upd_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_oxygen_flow    (m_oxygen_flow),
        .m_air_flow       (m_air_flow),
        .m_patient_flow   (m_patient_flow),
        .m_balance_error  (m_balance_error),
        .m_window_checked (m_window_checked)
    );

`ifndef SYNTH
    // input stalls only when every stage holds a block
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (blk_valid && !blk_ready))
        else $error("input stalled with room in the block stage");

    // a finished block is never dropped while the update stage is busy
    a_blk_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_valid && !blk_ready) |=> (blk_valid && $stable(blk_data)))
        else $error("block word lost while update stage stalled");

    // a new result word only comes out of the update stage
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(upd_valid))
        else $error("result word appeared without an update word");
`endif

endmodule

`default_nettype wire
